// ----- src/vdc_pkg.sv -----
// ----------------------------------------------------------------------------
// vdc_pkg
// Types and constants for the Van der Corput sequence generator.
// ----------------------------------------------------------------------------
package vdc_pkg;

  localparam int unsigned DIGITS     = 32;
  localparam int unsigned DIG_W      = 4;
  localparam int unsigned ADDR_W     = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam logic [0:0] ADDR_BASE = 1'b0;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_NEXT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] start_index;
  } vdc_in_t;

  typedef struct packed {
    logic [31:0] point;
    logic        wrapped;
  } vdc_out_t;

endpackage

// ----- src/van_der_corput_sequence.sv -----
// ----------------------------------------------------------------------------
// van_der_corput_sequence
// Radical inverse generator in a configurable base, digits held in a memory.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Payload
// in_     | input     | in_valid / in_ready    | vdc_in_t: kind, start_index
// out_    | output    | out_valid / out_ready  | vdc_out_t: point, wrapped
// cfg_    | input     | APB write, pready high | base at byte address 0
//
// Both items use one nibble-wide long division step by b per cycle, 8 per digit.
// Load: 32 digits of 8 steps, then idle again.
// Next: S_RD and S_SEED fetch the top digit, S_DIV divides through all digits, then
// S_IRD/S_IWR run for each digit the carry reaches (1 to 32 digits), then S_OUT.
// The output cycle stalls while the previous result is still unread.
// After reset a sweep clears all 32 digits of the memory; no item is taken then.
// ----------------------------------------------------------------------------
module van_der_corput_sequence (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vdc_pkg::vdc_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vdc_pkg::vdc_out_t    out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [0:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import vdc_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOAD, S_RD, S_SEED, S_DIV, S_IRD, S_IWR, S_OUT
  } state_t;

  state_t                state_r;
  logic [4:0]            base_r;
  logic [4:0]            b_r;
  logic [ADDR_W-1:0]     cnt_r;
  logic [2:0]            nib_r;
  logic [3:0]            rem_r;
  logic [31:0]           q_r;
  logic                  wrapped_r;
  logic                  out_valid_r;
  vdc_out_t              out_data_r;

  logic [DIG_W-1:0]      mem [DIGITS];
  logic [DIG_W-1:0]      rd_r;
  logic                  we;
  logic [DIG_W-1:0]      wdata;
  logic [ADDR_W-1:0]     raddr;

  logic [4:0]            b_eff;
  logic [4:0]            b_m1;
  logic [DIG_W-1:0]      d_sat;
  logic                  inc_wrap;
  logic                  nib_last;
  logic                  cnt_last;
  logic                  cfg_wr;
  logic [8:0]            sv;
  logic [3:0]            sq;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {27'd0, base_r};
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                    (cfg_paddr == ADDR_BASE);
  assign b_m1     = b_r - 5'd1;
  assign d_sat    = ({1'b0, rd_r} >= b_r) ? b_m1[DIG_W-1:0] : rd_r;
  assign inc_wrap = ({1'b0, rd_r} >= b_m1);
  assign nib_last = (nib_r == 3'd7);
  assign cnt_last = (cnt_r == ADDR_W'(DIGITS - 1));

  always_comb begin
    if (base_r < 5'd2) begin
      b_eff = 5'd2;
    end else if (base_r > 5'd16) begin
      b_eff = 5'd16;
    end else begin
      b_eff = base_r;
    end
  end

  // one long division step: {rem, top nibble} / b, rem < b keeps the quotient in 4 bits
  always_comb begin
    sv = {1'b0, rem_r, q_r[31:28]};
    sq = '0;
    for (int j = 3; j >= 0; j--) begin
      if (sv >= ({4'd0, b_r} << j)) begin
        sv    = sv - ({4'd0, b_r} << j);
        sq[j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[cnt_r] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_comb begin
    we    = 1'b0;
    wdata = '0;
    raddr = cnt_r;
    case (state_r)
      S_CLR: we = 1'b1;
      S_LOAD: begin
        we    = nib_last;
        wdata = sv[DIG_W-1:0];
      end
      // fetch the next lower digit while this one is divided
      S_DIV: raddr = cnt_r - ADDR_W'(1);
      S_IWR: begin
        we    = 1'b1;
        wdata = inc_wrap ? '0 : rd_r + 4'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      base_r      <= 5'd2;
      b_r         <= 5'd2;
      cnt_r       <= '0;
      nib_r       <= '0;
      rem_r       <= '0;
      q_r         <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (cfg_wr) begin
        base_r <= cfg_pwdata[4:0];
      end
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r        <= 1'b1;
        out_data_r.point   <= q_r;
        out_data_r.wrapped <= wrapped_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          cnt_r <= cnt_r + ADDR_W'(1);
          if (cnt_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            b_r   <= b_eff;
            nib_r <= '0;
            if (in_data.kind == KIND_LOAD) begin
              q_r     <= in_data.start_index;
              rem_r   <= '0;
              cnt_r   <= '0;
              state_r <= S_LOAD;
            end else begin
              q_r     <= '0;
              cnt_r   <= ADDR_W'(DIGITS - 1);
              state_r <= S_RD;
            end
          end
        end
        S_LOAD: begin
          // q_r is divided by b in place; the remainder is the digit
          q_r   <= {q_r[27:0], sq};
          nib_r <= nib_r + 3'd1;
          if (nib_last) begin
            rem_r <= '0;
            if (cnt_last) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r + ADDR_W'(1);
            end
          end else begin
            rem_r <= sv[3:0];
          end
        end
        S_RD: state_r <= S_SEED;
        S_SEED: begin
          rem_r   <= d_sat;
          nib_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          // (digit * 2^32 + q_r) / b, top digit first
          q_r   <= {q_r[27:0], sq};
          nib_r <= nib_r + 3'd1;
          if (nib_last) begin
            rem_r <= d_sat;
            if (cnt_r == '0) begin
              state_r <= S_IRD;
            end else begin
              cnt_r <= cnt_r - ADDR_W'(1);
            end
          end else begin
            rem_r <= sv[3:0];
          end
        end
        S_IRD: state_r <= S_IWR;
        S_IWR: begin
          if (inc_wrap && !cnt_last) begin
            cnt_r   <= cnt_r + ADDR_W'(1);
            state_r <= S_IRD;
          end else begin
            wrapped_r <= inc_wrap;
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb_van_der_corput_sequence.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_van_der_corput_sequence
// Drives load and next items through the generator under several radix
// settings, predicts each point and wrap flag from its own copy of the digit
// register, and checks every result in order, with random idling on both
// channels outside the stretch phases.
// ----------------------------------------------------------------------------
module tb_van_der_corput_sequence;
  import vdc_pkg::*;

  localparam int NDIG = 32;
  localparam int DRAIN_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  vdc_in_t in_data;
  vdc_out_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [0:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  van_der_corput_sequence dut (.*);

  vdc_in_t pending_items[$];
  vdc_out_t expected_points[$];
  logic [3:0] digit_model[NDIG];
  logic [4:0] radix_reg;
  int errors;
  int in_gap;
  int out_gap;
  bit drv_busy;
  logic in_ready_s, out_valid_s;
  bit stretch_mode;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned eff_radix();
    if (radix_reg < 2) return 2;
    if (radix_reg > 16) return 16;
    return 32'(radix_reg);
  endfunction

  // exact floor(x * 2^32) by long division, digits from the top
  function automatic vdc_out_t predict_next();
    vdc_out_t r;
    int unsigned b;
    logic [95:0] acc;
    int unsigned d;
    bit carry;
    b = eff_radix();
    acc = '0;
    for (int i = NDIG - 1; i >= 0; i--) begin
      d = 32'(digit_model[i]);
      if (d >= b) d = b - 1;
      acc = acc + (96'(d) << 32);
      acc = acc / b;
    end
    r.point = acc[31:0];
    carry = 1'b1;
    for (int i = 0; i < NDIG && carry; i++) begin
      if (digit_model[i] >= b - 1) digit_model[i] = '0;
      else begin
        digit_model[i] = 4'(digit_model[i] + 1);
        carry = 1'b0;
      end
    end
    r.wrapped = carry;
    return r;
  endfunction

  function automatic void load_digits(logic [31:0] k);
    int unsigned b;
    b = eff_radix();
    for (int i = 0; i < NDIG; i++) begin
      digit_model[i] = 4'(k % b);
      k = k / b;
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // handshake sampled at the rising edge, consumed by the driver
  always @(posedge clk) begin
    in_ready_s <= in_ready;
    out_valid_s <= out_valid;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_s) begin
        if (in_data.kind == KIND_NEXT) expected_points = {expected_points, predict_next()};
        else load_digits(in_data.start_index);
        in_gap = $urandom_range(0, 12);
        if (stretch_mode) in_gap = 0;
      end
      if (!(in_valid && !in_ready_s)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else in_valid <= 1'b0;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
      if (out_valid_s && out_ready) out_gap = stretch_mode ? 0 : $urandom_range(0, 12);
    end
  end

  // monitor
  always @(posedge clk) begin
    vdc_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) report_mismatch("result with none expected");
      else begin
        exp_r = expected_points.pop_front();
        if (out_data.point !== exp_r.point)
          report_mismatch($sformatf("point %h, expected %h", out_data.point, exp_r.point));
        if (out_data.wrapped !== exp_r.wrapped)
          report_mismatch($sformatf("wrapped %b, expected %b", out_data.wrapped,
                                    exp_r.wrapped));
      end
    end
  end

  task automatic write_radix(logic [31:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_BASE;
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    radix_reg = v[4:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic add_item(logic kind, logic [31:0] idx);
    vdc_in_t it;
    it.kind = kind;
    it.start_index = idx;
    pending_items = {pending_items, it};
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((pending_items.size() > 0 || in_valid || expected_points.size() > 0)
           && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int unsigned b;
    logic [31:0] top;
    b = eff_radix();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: add_item(KIND_LOAD, $urandom());
        1: begin
          // in base 2, land just below a wrap of the whole register
          top = 32'hFFFF_FFFF;
          if (b == 2) add_item(KIND_LOAD, top - $urandom_range(0, 3));
          else add_item(KIND_LOAD, $urandom());
        end
        default: add_item(KIND_NEXT, $urandom());
      endcase
    end
  endtask

  int unsigned radix_plan[9] = '{2, 16, 3, 10, 0, 31, 7, 5, 1};

  initial begin
    errors = 0;
    in_gap = 0;
    out_gap = 0;
    stretch_mode = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    radix_reg = 5'd2;
    for (int i = 0; i < NDIG; i++) digit_model[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (NDIG + 4) @(posedge clk);

    // directed: reset digits, extremes, wrap in base 2
    add_item(KIND_NEXT, '0);
    add_item(KIND_NEXT, 32'hFFFF_FFFF);
    add_item(KIND_LOAD, 32'hFFFF_FFFF);
    add_item(KIND_NEXT, '0);
    add_item(KIND_NEXT, '0);
    add_item(KIND_LOAD, 32'hFFFF_FFFE);
    add_item(KIND_NEXT, '0);
    add_item(KIND_NEXT, '0);
    add_item(KIND_LOAD, 32'h5555_AAAA);
    add_item(KIND_NEXT, '0);
    add_item(KIND_LOAD, '0);
    add_item(KIND_NEXT, '0);
    wait_idle();

    // base 16 with an overlarge-digit case after lowering the base
    write_radix(16);
    add_item(KIND_LOAD, 32'hFFFF_FFFF);
    add_item(KIND_NEXT, '0);
    add_item(KIND_LOAD, 32'hFEDC_BA98);
    add_item(KIND_NEXT, '0);
    wait_idle();
    write_radix(3);
    add_item(KIND_NEXT, '0);
    add_item(KIND_NEXT, '0);
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      write_radix(radix_plan[p]);
      stretch_mode = (p % 3 == 2);
      random_phase(100);
      wait_idle();
    end

    if (pending_items.size() != 0 || expected_points.size() != 0)
      report_mismatch("items left outstanding at the end");

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
